@@ rtl/squb_pkg.sv @@
// types, command codes and the baud divisor table shared by the bridge engine
// no dependencies
`default_nettype none

package squb_pkg;

    // request types on the input channel
    localparam logic [2:0] REQ_SPI_BYTE = 3'd0;
    localparam logic [2:0] REQ_UART_RX  = 3'd1;
    localparam logic [2:0] REQ_TX_POLL  = 3'd2;
    localparam logic [2:0] REQ_TX_DONE  = 3'd3;
    localparam logic [2:0] REQ_UART_ERR = 3'd4;
    localparam logic [2:0] REQ_SPI_OVR  = 3'd5;

    // spi command byte decode
    localparam logic [7:0] CMD_OP_FIELD = 8'hF0;
    localparam logic [7:0] CMD_RX_FILL  = 8'h10;
    localparam logic [7:0] CMD_GET      = 8'h20;
    localparam logic [7:0] CMD_TX_FILL  = 8'h30;
    localparam logic [7:0] CMD_PUT      = 8'h40;
    localparam logic [7:0] CMD_BAUD     = 8'h80;

    localparam logic [7:0] REPLY_BAD     = 8'hFF;
    localparam logic [7:0] FILL_MAX      = 8'hFF;
    localparam logic [7:0] BAUD_CODE_MAX = 8'd7;
    localparam logic [9:0] DIV_9600      = 10'd103;

    localparam int RING_SEL_W = 3;

    // ring access request and ring status between the engine and the ring control
    typedef struct packed {
        logic                  pop;
        logic                  push;
        logic [7:0]            wdata;
    } t_ring_req;

    typedef struct packed {
        logic       empty;
        logic [7:0] fill;
    } t_ring_sts;

    // divisors for a 32 MHz clock, codes 1200 baud up to 115200 baud
    function automatic logic [9:0] baud_div(input logic [2:0] code);
        logic [9:0] d;
        case (code)
            3'd0:    d = 10'd833;
            3'd1:    d = 10'd416;
            3'd2:    d = 10'd208;
            3'd3:    d = 10'd103;
            3'd4:    d = 10'd51;
            3'd5:    d = 10'd25;
            3'd6:    d = 10'd17;
            3'd7:    d = 10'd8;
            default: d = 10'd833;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

@@ rtl/squb_ram.sv @@
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module squb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port, read data holds without a read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/squb_ring_ctl.sv @@
// eight byte rings: read and write pointer tables plus the shared byte ram
// depends on squb_pkg and squb_ram
`default_nettype none

module squb_ring_ctl #(
    parameter int RING_DEPTH = 512
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [squb_pkg::RING_SEL_W-1:0]     i_ring,
    input  wire squb_pkg::t_ring_req                 i_req,
    output squb_pkg::t_ring_sts                      o_sts,
    output logic [7:0]                               o_rdata
);
    import squb_pkg::*;

    localparam int PW     = $clog2(RING_DEPTH);
    localparam int FW     = (PW > 8) ? PW : 8;
    localparam int NRINGS = 1 << RING_SEL_W;
    localparam int AW     = RING_SEL_W + PW;
    localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);
    localparam logic [PW:0]   DEPTH_W  = (PW + 1)'(RING_DEPTH);

    logic [PW-1:0] r_rd [NRINGS];
    logic [PW-1:0] r_wr [NRINGS];

    logic [PW-1:0] rd, wr, rd_inc, wr_inc, fill;
    logic [PW:0]   fill_w;
    logic [FW-1:0] fill_ext;
    logic          pop_do, push_do;

    // pointers of the selected ring
    assign rd     = r_rd[i_ring];
    assign wr     = r_wr[i_ring];
    assign rd_inc = (rd == PTR_LAST) ? '0 : rd + 1'b1;
    assign wr_inc = (wr == PTR_LAST) ? '0 : wr + 1'b1;

    // fill count, saturated to one byte
    assign fill_w   = (wr >= rd) ? ({1'b0, wr} - {1'b0, rd}) : (DEPTH_W - {1'b0, rd} + {1'b0, wr});
    assign fill     = fill_w[PW-1:0];
    assign fill_ext = FW'(fill);

    assign o_sts.empty = (rd == wr);
    assign o_sts.fill  = (fill_ext > FW'(FILL_MAX)) ? FILL_MAX : fill_ext[7:0];

    // pop only from a non-empty ring, a push into a full ring is dropped
    assign pop_do  = i_req.pop && (rd != wr);
    assign push_do = i_req.push && (wr_inc != rd);

    // pointer update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NRINGS; k++) begin
                r_rd[k] <= '0;
                r_wr[k] <= '0;
            end
        end else begin
            if (pop_do) begin
                r_rd[i_ring] <= rd_inc;
            end
            if (push_do) begin
                r_wr[i_ring] <= wr_inc;
            end
        end
    end

    // byte store, one row of 2**PW entries per ring
    squb_ram #(
        .WIDTH (8),
        .DEPTH (NRINGS << PW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (push_do),
        .i_waddr (AW'({i_ring, wr})),
        .i_wdata (i_req.wdata),
        .i_re    (pop_do),
        .i_raddr (AW'({i_ring, rd})),
        .o_rdata (o_rdata)
    );

endmodule

`default_nettype wire

@@ rtl/spi_to_quad_uart_bridge_engine_core.sv @@
// top level of the spi to quad uart bridge command engine
// depends on squb_pkg and squb_ring_ctl
//
// Input channel (i_valid / o_stall) carries one event per item: an spi byte
// from the host, a uart receive byte, a transmit poll, a transmit done, a
// uart error or an spi overrun. The output channel (o_valid / i_stall) carries
// result items: a reply byte for the next spi transfer, a byte for a uart
// transmitter, or a baud divisor update, with o_last on the final result of
// an event. Events that cause no result produce nothing on the output.
// An item is decoded in the cycle it is accepted, while the ring ram read is
// issued; the decode stage then merges the ram data and loads the output
// register once that is free. One event is accepted per cycle while o_stall
// is low; a uart error holds the output register for its 4 results, which
// sets the rate for error events. When i_stall is high the output register
// holds and o_stall rises once the decode stage is also full, so nothing is
// lost. Reset clears the pointers, the command phase and the busy flags; the
// ring ram needs no clearing pass, since only written entries are ever read.

`default_nettype none

module spi_to_quad_uart_bridge_engine_core #(
    parameter int RING_DEPTH = 512
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [2:0] i_req_type,
    input  wire logic [1:0] i_channel,
    input  wire logic [7:0] i_data,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_spi_valid,
    output logic [7:0]      o_spi_byte,
    output logic            o_tx_valid,
    output logic [1:0]      o_tx_channel,
    output logic [7:0]      o_tx_byte,
    output logic            o_baud_valid,
    output logic [1:0]      o_baud_channel,
    output logic [9:0]      o_baud_divisor,
    output logic            o_last
);
    import squb_pkg::*;

    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_GET_LEN  = 7'b0000010,
        PH_PUT_LEN  = 7'b0000100,
        PH_GET_DATA = 7'b0001000,
        PH_PUT_DATA = 7'b0010000,
        PH_BAUD     = 7'b0100000,
        PH_DRAIN    = 7'b1000000
    } t_phase;

    // decoded item waiting for its ram read data
    typedef struct packed {
        logic       has;
        logic       err;
        logic       spi_valid;
        logic       spi_from_ram;
        logic [7:0] spi_byte;
        logic       tx_valid;
        logic [1:0] tx_channel;
        logic       baud_valid;
        logic [1:0] baud_channel;
        logic [9:0] baud_divisor;
    } t_dec;

    // result held in the output register
    typedef struct packed {
        logic       err;
        logic       spi_valid;
        logic [7:0] spi_byte;
        logic       tx_valid;
        logic [1:0] tx_channel;
        logic [7:0] tx_byte;
        logic       baud_valid;
        logic [1:0] baud_channel;
        logic [9:0] baud_divisor;
    } t_res;

    t_phase     r_phase, n_phase;
    logic [1:0] r_cmd_ch, n_cmd_ch;
    logic [7:0] r_xfer_len, n_xfer_len;
    logic [7:0] r_xfer_idx, n_xfer_idx;
    logic [3:0] r_busy, n_busy;

    logic       r_s1_valid;
    t_dec       r_s1;
    logic       r_out_valid;
    t_res       r_out;
    logic [1:0] r_res_idx;

    t_dec                  dec;
    t_res                  res;
    logic [RING_SEL_W-1:0] ring_sel;
    t_ring_req             ring_req;
    t_ring_req             ring_cmd;
    t_ring_sts             ring_sts;
    logic [7:0]            ring_rdata;
    logic                  acc, out_fire, out_free, s1_adv;

    // handshake
    assign out_fire = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || (out_fire && o_last);
    assign s1_adv   = r_s1_valid && out_free;
    assign o_stall  = r_s1_valid && !out_free;
    assign acc      = i_valid && !o_stall;

    // ring addressed by the item: rx rings 0..3, tx rings 4..7
    always_comb begin
        ring_sel = {1'b0, i_channel};
        case (i_req_type)
            REQ_SPI_BYTE: begin
                case (r_phase)
                    PH_IDLE: begin
                        ring_sel = {((i_data & CMD_OP_FIELD) == CMD_TX_FILL), i_data[1:0]};
                    end
                    PH_GET_LEN, PH_GET_DATA: ring_sel = {1'b0, r_cmd_ch};
                    PH_PUT_DATA:             ring_sel = {1'b1, r_cmd_ch};
                    default:                 ring_sel = {1'b0, i_channel};
                endcase
            end
            REQ_TX_POLL, REQ_TX_DONE: ring_sel = {1'b1, i_channel};
            default:                  ring_sel = {1'b0, i_channel};
        endcase
    end

    // item decode and next state
    always_comb begin
        n_phase    = r_phase;
        n_cmd_ch   = r_cmd_ch;
        n_xfer_len = r_xfer_len;
        n_xfer_idx = r_xfer_idx;
        n_busy     = r_busy;
        ring_req   = '{pop: 1'b0, push: 1'b0, wdata: i_data};
        dec        = '0;
        dec.spi_byte = i_data;
        case (i_req_type)
            REQ_SPI_BYTE: begin
                dec.has       = 1'b1;
                dec.spi_valid = 1'b1;
                case (r_phase)
                    PH_IDLE: begin
                        n_cmd_ch = i_data[1:0];
                        case (i_data & CMD_OP_FIELD)
                            CMD_RX_FILL: begin
                                n_phase      = PH_DRAIN;
                                dec.spi_byte = ring_sts.fill;
                            end
                            CMD_TX_FILL: begin
                                n_phase      = PH_DRAIN;
                                dec.spi_byte = ring_sts.fill;
                            end
                            CMD_GET:  n_phase = PH_GET_LEN;
                            CMD_PUT:  n_phase = PH_PUT_LEN;
                            CMD_BAUD: n_phase = PH_BAUD;
                            default: begin
                                n_phase      = PH_IDLE;
                                dec.spi_byte = REPLY_BAD;
                            end
                        endcase
                    end
                    PH_GET_LEN: begin
                        n_xfer_len       = i_data;
                        ring_req.pop     = 1'b1;
                        dec.spi_byte     = '0;
                        dec.spi_from_ram = !ring_sts.empty;
                        n_xfer_idx       = 8'd1;
                        n_phase          = PH_GET_DATA;
                    end
                    PH_PUT_LEN: begin
                        n_xfer_len = i_data;
                        n_xfer_idx = '0;
                        n_phase    = PH_PUT_DATA;
                    end
                    PH_GET_DATA: begin
                        if (r_xfer_idx < r_xfer_len) begin
                            ring_req.pop     = 1'b1;
                            dec.spi_byte     = '0;
                            dec.spi_from_ram = !ring_sts.empty;
                            n_xfer_idx       = r_xfer_idx + 8'd1;
                        end
                        if (n_xfer_idx >= r_xfer_len) begin
                            n_phase = PH_DRAIN;
                        end
                    end
                    PH_PUT_DATA: begin
                        if (r_xfer_idx < r_xfer_len) begin
                            ring_req.push = 1'b1;
                            n_xfer_idx    = r_xfer_idx + 8'd1;
                        end
                        if (n_xfer_idx >= r_xfer_len) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_BAUD: begin
                        if (i_data <= BAUD_CODE_MAX) begin
                            dec.baud_valid   = 1'b1;
                            dec.baud_channel = r_cmd_ch;
                            dec.baud_divisor = baud_div(i_data[2:0]);
                        end
                        n_phase = PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            REQ_UART_RX: begin
                ring_req.push = 1'b1;
            end
            REQ_TX_POLL: begin
                dec.spi_byte = '0;
                if (!ring_sts.empty && !r_busy[i_channel]) begin
                    n_busy[i_channel] = 1'b1;
                    ring_req.pop      = 1'b1;
                    dec.has           = 1'b1;
                    dec.tx_valid      = 1'b1;
                    dec.tx_channel    = i_channel;
                end
            end
            REQ_TX_DONE: begin
                dec.spi_byte = '0;
                if (!ring_sts.empty) begin
                    ring_req.pop   = 1'b1;
                    dec.has        = 1'b1;
                    dec.tx_valid   = 1'b1;
                    dec.tx_channel = i_channel;
                end else begin
                    n_busy[i_channel] = 1'b0;
                end
            end
            REQ_UART_ERR: begin
                dec.spi_byte     = '0;
                dec.has          = 1'b1;
                dec.err          = 1'b1;
                dec.baud_valid   = 1'b1;
                dec.baud_divisor = DIV_9600;
            end
            REQ_SPI_OVR: begin
                n_phase       = PH_IDLE;
                dec.has       = 1'b1;
                dec.spi_valid = 1'b1;
                dec.spi_byte  = '0;
            end
            default: begin
                dec.spi_byte = '0;
            end
        endcase
    end

    // ring operations only for accepted items
    always_comb begin
        ring_cmd      = ring_req;
        ring_cmd.pop  = ring_req.pop && acc;
        ring_cmd.push = ring_req.push && acc;
    end

    squb_ring_ctl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_rings (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ring  (ring_sel),
        .i_req   (ring_cmd),
        .o_sts   (ring_sts),
        .o_rdata (ring_rdata)
    );

    // command state and busy flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_cmd_ch   <= '0;
            r_xfer_len <= '0;
            r_xfer_idx <= '0;
            r_busy     <= '0;
        end else if (acc) begin
            r_phase    <= n_phase;
            r_cmd_ch   <= n_cmd_ch;
            r_xfer_len <= n_xfer_len;
            r_xfer_idx <= n_xfer_idx;
            r_busy     <= n_busy;
        end
    end

    // merge ram read data into the decoded item
    always_comb begin
        res.err          = r_s1.err;
        res.spi_valid    = r_s1.spi_valid;
        res.spi_byte     = r_s1.spi_from_ram ? ring_rdata : r_s1.spi_byte;
        res.tx_valid     = r_s1.tx_valid;
        res.tx_channel   = r_s1.tx_channel;
        res.tx_byte      = r_s1.tx_valid ? ring_rdata : 8'h00;
        res.baud_valid   = r_s1.baud_valid;
        res.baud_channel = r_s1.baud_channel;
        res.baud_divisor = r_s1.baud_divisor;
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_res_idx   <= '0;
        end else begin
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1.has;
                r_res_idx   <= '0;
            end else if (out_fire) begin
                if (o_last) begin
                    r_out_valid <= 1'b0;
                end else begin
                    r_res_idx <= r_res_idx + 2'd1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= dec;
        end
        if (s1_adv) begin
            r_out <= res;
        end
    end

    // outputs, a uart error steps through all four channels
    assign o_valid        = r_out_valid;
    assign o_spi_valid    = r_out.spi_valid;
    assign o_spi_byte     = r_out.spi_byte;
    assign o_tx_valid     = r_out.tx_valid;
    assign o_tx_channel   = r_out.tx_channel;
    assign o_tx_byte      = r_out.tx_byte;
    assign o_baud_valid   = r_out.baud_valid;
    assign o_baud_channel = r_out.err ? r_res_idx : r_out.baud_channel;
    assign o_baud_divisor = r_out.baud_divisor;
    assign o_last         = !r_out.err || (r_res_idx == 2'd3);

endmodule

`default_nettype wire
